FILE: hw/rtl/s3tc_pkg.sv
// Shared types, constants and helpers for the texture block decoder.
`timescale 1ns / 1ps

package s3tc_pkg;

  // Block format codes held in the format register.
  typedef enum logic [1:0] {
    FMT_DXT1 = 2'd0,
    FMT_DXT3 = 2'd1,
    FMT_DXT5 = 2'd2
  } fmt_e;

  // Reciprocal multipliers for truncating division of small sums.
  localparam int unsigned DIV3_MUL  = 683;
  localparam int unsigned DIV3_SH   = 11;
  localparam int unsigned DIV5_MUL  = 3277;
  localparam int unsigned DIV7_MUL  = 2341;
  localparam int unsigned DIV57_SH  = 14;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [7:0] ALPHA_ZERO   = 8'h00;

  // Register after end-point expansion and weighted sums.
  typedef struct packed {
    fmt_e                  fmt;
    logic                  four_mode;
    logic [2:0][7:0]       ep0;
    logic [2:0][7:0]       ep1;
    logic [2:0][9:0]       sum_2_1;
    logic [2:0][9:0]       sum_1_2;
    logic [2:0][7:0]       half;
    logic [7:0]            a0;
    logic [7:0]            a1;
    logic                  a_gt;
    logic [5:0][10:0]      sum7;
    logic [3:0][10:0]      sum5;
    logic [31:0]           cidx;
    logic [63:0]           aword;
  } exp_t;

  // Register holding the finished palette and alpha levels.
  typedef struct packed {
    fmt_e                  fmt;
    logic [3:0][31:0]      pal;
    logic [7:0][7:0]       lv;
    logic [31:0]           cidx;
    logic [63:0]           aword;
  } pal_t;

  // Expand an RGB565 color to 8 bits per channel by bit replication.
  // Channel order is {red, green, blue} from high to low.
  function automatic logic [2:0][7:0] expand565(input logic [15:0] c);
    logic [2:0][7:0] rgb;
    rgb[2] = {c[15:11], c[15:13]};
    rgb[1] = {c[10:5], c[10:9]};
    rgb[0] = {c[4:0], c[4:2]};
    return rgb;
  endfunction

endpackage

FILE: hw/rtl/s3tc_expand.sv
// First compute stage: end-point expansion and weighted sums for blends.
`timescale 1ns / 1ps

module s3tc_expand (
  input  logic                clk_i,
  input  logic                en_i,
  input  s3tc_pkg::fmt_e      fmt_i,
  input  logic [63:0]         fw_i,
  input  logic [63:0]         sw_i,
  output s3tc_pkg::exp_t      exp_o
);

  s3tc_pkg::exp_t exp_d, exp_q;

  // Decode both end points and form the sums that the divisions need.
  always_comb begin
    logic [63:0] cw;
    logic [15:0] c0;
    logic [15:0] c1;
    cw = (fmt_i == s3tc_pkg::FMT_DXT1) ? fw_i : sw_i;
    c0 = cw[15:0];
    c1 = cw[31:16];
    exp_d = '0;
    exp_d.fmt       = fmt_i;
    exp_d.four_mode = (fmt_i != s3tc_pkg::FMT_DXT1) || (c0 > c1);
    exp_d.ep0       = s3tc_pkg::expand565(c0);
    exp_d.ep1       = s3tc_pkg::expand565(c1);
    for (int k = 0; k < 3; k++) begin
      exp_d.sum_2_1[k] = {1'b0, exp_d.ep0[k], 1'b0} + {2'b00, exp_d.ep1[k]};
      exp_d.sum_1_2[k] = {2'b00, exp_d.ep0[k]} + {1'b0, exp_d.ep1[k], 1'b0};
      exp_d.half[k]    = 8'(({1'b0, exp_d.ep0[k]} + {1'b0, exp_d.ep1[k]}) >> 1);
    end
    exp_d.a0   = fw_i[7:0];
    exp_d.a1   = fw_i[15:8];
    exp_d.a_gt = fw_i[7:0] > fw_i[15:8];
    for (int i = 1; i <= 6; i++) begin
      exp_d.sum7[i-1] = 11'(7 - i) * {3'b000, fw_i[7:0]} + 11'(i) * {3'b000, fw_i[15:8]};
    end
    for (int i = 1; i <= 4; i++) begin
      exp_d.sum5[i-1] = 11'(5 - i) * {3'b000, fw_i[7:0]} + 11'(i) * {3'b000, fw_i[15:8]};
    end
    exp_d.cidx  = cw[63:32];
    exp_d.aword = fw_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      exp_q <= exp_d;
    end
  end

  assign exp_o = exp_q;

endmodule

FILE: hw/rtl/s3tc_palette.sv
// Second compute stage: truncating divisions into the color palette and alpha levels.
`timescale 1ns / 1ps

module s3tc_palette (
  input  logic                clk_i,
  input  logic                en_i,
  input  s3tc_pkg::exp_t      exp_i,
  output s3tc_pkg::pal_t      pal_o
);

  s3tc_pkg::pal_t pal_d, pal_q;

  logic [2:0][18:0] prod_2_1;
  logic [2:0][18:0] prod_1_2;
  logic [2:0][7:0]  q_2_1;
  logic [2:0][7:0]  q_1_2;
  logic [5:0][21:0] prod7;
  logic [3:0][21:0] prod5;

  // Divide by three per channel with a reciprocal multiply.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      prod_2_1[k] = 19'(exp_i.sum_2_1[k]) * 19'(s3tc_pkg::DIV3_MUL);
      prod_1_2[k] = 19'(exp_i.sum_1_2[k]) * 19'(s3tc_pkg::DIV3_MUL);
      q_2_1[k]    = 8'(prod_2_1[k] >> s3tc_pkg::DIV3_SH);
      q_1_2[k]    = 8'(prod_1_2[k] >> s3tc_pkg::DIV3_SH);
    end
  end

  // Divide the alpha sums by seven and by five.
  always_comb begin
    for (int i = 0; i < 6; i++) begin
      prod7[i] = 22'(exp_i.sum7[i]) * 22'(s3tc_pkg::DIV7_MUL);
    end
    for (int i = 0; i < 4; i++) begin
      prod5[i] = 22'(exp_i.sum5[i]) * 22'(s3tc_pkg::DIV5_MUL);
    end
  end

  // Assemble the palette and the eight alpha levels.
  always_comb begin
    pal_d        = '0;
    pal_d.fmt    = exp_i.fmt;
    pal_d.cidx   = exp_i.cidx;
    pal_d.aword  = exp_i.aword;
    pal_d.pal[0] = {s3tc_pkg::ALPHA_OPAQUE, exp_i.ep0};
    pal_d.pal[1] = {s3tc_pkg::ALPHA_OPAQUE, exp_i.ep1};
    if (exp_i.four_mode) begin
      pal_d.pal[2] = {s3tc_pkg::ALPHA_OPAQUE, q_2_1};
      pal_d.pal[3] = {s3tc_pkg::ALPHA_OPAQUE, q_1_2};
    end else begin
      pal_d.pal[2] = {s3tc_pkg::ALPHA_OPAQUE, exp_i.half};
      pal_d.pal[3] = '0;
    end
    pal_d.lv[0] = exp_i.a0;
    pal_d.lv[1] = exp_i.a1;
    if (exp_i.a_gt) begin
      for (int i = 0; i < 6; i++) begin
        pal_d.lv[i+2] = 8'(prod7[i] >> s3tc_pkg::DIV57_SH);
      end
    end else begin
      for (int i = 0; i < 4; i++) begin
        pal_d.lv[i+2] = 8'(prod5[i] >> s3tc_pkg::DIV57_SH);
      end
      pal_d.lv[6] = s3tc_pkg::ALPHA_ZERO;
      pal_d.lv[7] = s3tc_pkg::ALPHA_OPAQUE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pal_q <= pal_d;
    end
  end

  assign pal_o = pal_q;

endmodule

FILE: hw/rtl/s3tc_row_out.sv
// Row serializer: holds one decoded block and issues its four rows into the output register.
`timescale 1ns / 1ps

module s3tc_row_out (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  s3tc_pkg::pal_t      pal_i,
  output logic                free_o,
  output logic                idle_o,
  output logic                valid_o,
  output logic [31:0]         texel_x0_o,
  output logic [31:0]         texel_x1_o,
  output logic [31:0]         texel_x2_o,
  output logic [31:0]         texel_x3_o,
  output logic [1:0]          row_number_o,
  output logic                last_row_o
);

  s3tc_pkg::pal_t blk_q;
  logic           busy_d, busy_q;
  logic [1:0]     row_d, row_q;

  logic [3:0][31:0] texel_d, texel_q;
  logic             out_valid_q;
  logic [1:0]       out_row_q;

  // The holding register takes a new block while its last row goes out.
  assign free_o = !busy_q || (row_q == 2'd3);

  // Nothing is held and no row is on the output.
  assign idle_o = !busy_q && !out_valid_q;

  always_comb begin
    busy_d = busy_q;
    row_d  = row_q;
    if (load_i) begin
      busy_d = 1'b1;
      row_d  = 2'd0;
    end else if (busy_q) begin
      row_d = row_q + 2'd1;
      if (row_q == 2'd3) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      row_q  <= 2'd0;
    end else begin
      busy_q <= busy_d;
      row_q  <= row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      blk_q <= pal_i;
    end
  end

  // Look up the four texels of the current row.
  always_comb begin
    logic [3:0]  lin;
    logic [1:0]  ci;
    logic [3:0]  nib;
    logic [2:0]  ai;
    logic [5:0]  apos;
    logic [7:0]  alpha;
    logic [31:0] p;
    for (int x = 0; x < 4; x++) begin
      lin  = {row_q, 2'(x)};
      ci   = blk_q.cidx[{lin, 1'b0} +: 2];
      p    = blk_q.pal[ci];
      nib  = blk_q.aword[{lin, 2'b00} +: 4];
      apos = 6'd16 + {2'b00, lin} + {1'b0, lin, 1'b0};
      ai   = blk_q.aword[apos +: 3];
      case (blk_q.fmt)
        s3tc_pkg::FMT_DXT1: alpha = p[31:24];
        s3tc_pkg::FMT_DXT3: alpha = {nib, nib};
        default:            alpha = blk_q.lv[ai];
      endcase
      texel_d[x] = {alpha, p[23:0]};
    end
  end

  // Output register; every row is shown for exactly one cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= busy_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      texel_q   <= texel_d;
      out_row_q <= row_q;
    end
  end

  assign valid_o      = out_valid_q;
  assign texel_x0_o   = texel_q[0];
  assign texel_x1_o   = texel_q[1];
  assign texel_x2_o   = texel_q[2];
  assign texel_x3_o   = texel_q[3];
  assign row_number_o = out_row_q;
  assign last_row_o   = (out_row_q == 2'd3);

endmodule

FILE: hw/rtl/s3tc_block_decoder.sv
// Top level of the DXT1/DXT3/DXT5 texture block decoder.
//
//  channel   signals                                   direction  handshake
//  block     start_i, busy_o, first_word_i,            in         start_i && !busy_o
//            second_word_i
//  rows      valid_o, texel_x0_o..texel_x3_o,          out        valid_o, one cycle each
//            row_number_o, last_row_o
//  format    cfg_valid_i, cfg_ready_o, cfg_data_i      in         cfg_valid_i && cfg_ready_o
//
// Each item passes an input register, the end-point stage and the palette stage, then the
// row serializer, which puts out its four rows on consecutive cycles from its holding
// register through its output register. The serializer takes a new item only when empty or
// while the last row of the one before goes out, and the row port cannot be held off. Items
// enter back to back until the stages fill up, and busy_o rises while the input register
// cannot move on. Reset clears all valid bits and sets the format to DXT1.
`timescale 1ns / 1ps

module s3tc_block_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [63:0] first_word_i,
  input  logic [63:0] second_word_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_data_i,
  output logic        valid_o,
  output logic [31:0] texel_x0_o,
  output logic [31:0] texel_x1_o,
  output logic [31:0] texel_x2_o,
  output logic [31:0] texel_x3_o,
  output logic [1:0]  row_number_o,
  output logic        last_row_o
);

  s3tc_pkg::fmt_e fmt_q;

  logic           valid_a_q, valid_b_q, valid_c_q;
  logic [63:0]    fw_a_q, sw_a_q;
  s3tc_pkg::fmt_e fmt_a_q;

  logic           accept;
  logic           a_free, b_free, c_free;
  logic           d_free, d_load, d_idle;

  s3tc_pkg::exp_t exp_b;
  s3tc_pkg::pal_t pal_c;

  // Format register; it is written only while no item is in flight or being offered.
  assign cfg_ready_o = !start_i && !valid_a_q && !valid_b_q && !valid_c_q && d_idle;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= s3tc_pkg::FMT_DXT1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      fmt_q <= s3tc_pkg::fmt_e'(cfg_data_i);
    end
  end

  // Stall chain: a stage moves on when the stage after it is empty or moving.
  assign d_load = valid_c_q && d_free;
  assign c_free = !valid_c_q || d_free;
  assign b_free = !valid_b_q || c_free;
  assign a_free = !valid_a_q || b_free;
  assign busy_o = !a_free;
  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
      valid_c_q <= 1'b0;
    end else begin
      if (a_free) begin
        valid_a_q <= accept;
      end
      if (b_free) begin
        valid_b_q <= valid_a_q;
      end
      if (c_free) begin
        valid_c_q <= valid_b_q;
      end
    end
  end

  // Input register.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      fw_a_q  <= first_word_i;
      sw_a_q  <= second_word_i;
      fmt_a_q <= fmt_q;
    end
  end

  s3tc_expand u_expand (
    .clk_i (clk_i),
    .en_i  (b_free && valid_a_q),
    .fmt_i (fmt_a_q),
    .fw_i  (fw_a_q),
    .sw_i  (sw_a_q),
    .exp_o (exp_b)
  );

  s3tc_palette u_palette (
    .clk_i (clk_i),
    .en_i  (c_free && valid_b_q),
    .exp_i (exp_b),
    .pal_o (pal_c)
  );

  s3tc_row_out u_row_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (d_load),
    .pal_i        (pal_c),
    .free_o       (d_free),
    .idle_o       (d_idle),
    .valid_o      (valid_o),
    .texel_x0_o   (texel_x0_o),
    .texel_x1_o   (texel_x1_o),
    .texel_x2_o   (texel_x2_o),
    .texel_x3_o   (texel_x3_o),
    .row_number_o (row_number_o),
    .last_row_o   (last_row_o)
  );

  // Rows of one block come out on consecutive cycles in order.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !last_row_o |=> valid_o && (row_number_o == $past(row_number_o) + 2'd1))
    else $error("row sequence broken");

  // Busy is only raised when every stage before the serializer holds an item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> valid_a_q && valid_b_q && valid_c_q)
    else $error("busy with an empty stage");

  // A stalled palette stage keeps its item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_c_q && !c_free |=> valid_c_q)
    else $error("item dropped from palette stage");

  // A block loaded into the serializer shows up as row 0 after its holding and output registers.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    d_load |=> ##1 (valid_o && (row_number_o == 2'd0)))
    else $error("loaded block did not start at row 0");

endmodule
